@@ hw/rtl/http_request_framer_macros.svh @@
// assertion macros for the checker
`ifndef HTTP_REQUEST_FRAMER_MACROS_SVH
`define HTTP_REQUEST_FRAMER_MACROS_SVH

// checked only while out of reset
`define HRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HRF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hrf_pkg.sv @@
package hrf_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int KEY_LENGTH = 14;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] HEADER_LIMIT_RST = 16'd8192;
	localparam logic [30:0] BODY_LIMIT_RST = 31'd1048576;
	localparam logic [31:0] TERMINATOR = 32'h0D0A_0D0A;

	localparam logic [7:0] CHAR_CR = 8'h0D;

	// register index
	localparam logic REG_HEADER_LIMIT = 1'b0;
	localparam logic REG_BODY_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_PENDING = 3'd0,
		ST_COMPLETE = 3'd1,
		ST_HEADER_TOO_LARGE = 3'd2,
		ST_BODY_TOO_LARGE = 3'd3,
		ST_CLOSED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_KEY = 2'd0,
		PH_SKIP = 2'd1,
		PH_VALUE = 2'd2,
		PH_IGNORE = 2'd3
	} line_phase_t;

	typedef struct packed {
		logic       is_colon;
		logic       is_space;
		logic       is_digit;
		logic       is_cr;
		logic       is_lf;
		logic [3:0] digit_val;
		logic [7:0] lc;
	} byte_class_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		byte_class_t cls;
	} item_t;

	typedef struct packed {
		logic [3:0]  key_len;
		logic        key_match;
		line_phase_t phase;
		logic        digit_seen;
		logic        value_err;
		logic        key_found;
	} parse_ctl_t;

	localparam byte_class_t CR_CLASS = '{
		is_colon: 1'b0, is_space: 1'b0, is_digit: 1'b0, is_cr: 1'b1,
		is_lf: 1'b0, digit_val: 4'd0, lc: CHAR_CR};

	localparam parse_ctl_t CTL_RST = '{
		key_len: 4'd0, key_match: 1'b1, phase: PH_KEY,
		digit_seen: 1'b0, value_err: 1'b0, key_found: 1'b0};

	// lower-case text of the key
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = "c";
			4'd1: c = "o";
			4'd2: c = "n";
			4'd3: c = "t";
			4'd4: c = "e";
			4'd5: c = "n";
			4'd6: c = "t";
			4'd7: c = "-";
			4'd8: c = "l";
			4'd9: c = "e";
			4'd10: c = "n";
			4'd11: c = "g";
			4'd12: c = "t";
			4'd13: c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/hrf_front.sv @@
module hrf_front
	import hrf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_kind,
	input  logic [7:0] in_byte,
	output logic       push_valid,
	input  logic       push_ready,
	output item_t      push_item
);

	logic        valid_s1;
	item_t       item_s1;
	byte_class_t cls;

	always_comb begin
		cls = '0;
		cls.is_colon = (in_byte == ":");
		cls.is_space = (in_byte == " ");
		cls.is_cr = (in_byte == 8'h0D);
		cls.is_lf = (in_byte == 8'h0A);
		cls.is_digit = (in_byte inside {["0":"9"]});
		cls.digit_val = in_byte[3:0];
		if (in_byte inside {["A":"Z"]}) begin
			cls.lc = in_byte | 8'h20;
		end else begin
			cls.lc = in_byte;
		end
	end

	assign in_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind <= in_kind;
			item_s1.data_byte <= in_byte;
			item_s1.cls <= cls;
		end
	end

endmodule

@@ hw/rtl/hrf_queue.sv @@
module hrf_queue
	import hrf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ hw/rtl/hrf_back.sv @@
module hrf_back
	import hrf_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  item_t       pop_item,
	input  logic [15:0] header_limit,
	input  logic [30:0] body_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output status_t     out_status,
	output logic [31:0] out_req_len,
	output logic [30:0] out_body_len
);

	localparam int PROD_W = VALUE_BITS + 4;

	// request state
	logic [31:0]            byte_count_q, byte_count_d;
	logic                   in_body_q, in_body_d;
	logic [31:0]            window_q, window_d;
	parse_ctl_t             ctl_q, ctl_d;
	logic [VALUE_BITS-1:0]  accum_q, accum_d;
	logic                   held_cr_q, held_cr_d;
	logic [31:0]            target_q, target_d;

	// result register
	logic                   out_valid_q;
	status_t                status_q, status_d;
	logic [31:0]            req_len_q, req_len_d;
	logic [30:0]            body_len_q, body_len_d;

	logic                   take;
	logic [31:0]            cnt1;
	logic [PROD_W-1:0]      prod;
	logic                   ovf;
	parse_ctl_t             ctl_a;
	logic                   feed_byte;
	logic [VALUE_BITS-1:0]  cl;
	logic                   term_hit;

	function automatic parse_ctl_t feed(input parse_ctl_t c, input byte_class_t b,
		input logic of);
		parse_ctl_t n;
		logic       val;
		n = c;
		val = 1'b0;
		case (c.phase)
			PH_KEY: begin
				if (b.is_colon) begin
					if (c.key_len == 4'(KEY_LENGTH) && c.key_match) begin
						n.key_found = 1'b1;
						n.phase = PH_SKIP;
					end else begin
						n.phase = PH_IGNORE;
					end
				end else if (c.key_len < 4'(KEY_LENGTH)) begin
					if (b.lc != key_char(c.key_len)) begin
						n.key_match = 1'b0;
					end
					n.key_len = c.key_len + 1'b1;
				end else begin
					n.key_len = 4'(KEY_LENGTH + 1);
				end
			end
			PH_SKIP: begin
				if (!b.is_space) begin
					n.phase = PH_VALUE;
					val = 1'b1;
				end
			end
			PH_VALUE: val = 1'b1;
			default: ;
		endcase
		if (val) begin
			if (b.is_digit) begin
				n.digit_seen = 1'b1;
				if (of) begin
					n.value_err = 1'b1;
				end
			end else begin
				n.value_err = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic parse_ctl_t end_line(input parse_ctl_t c);
		parse_ctl_t n;
		n = c;
		if (c.key_found) begin
			n.phase = PH_IGNORE;
		end else begin
			n.phase = PH_KEY;
			n.key_len = '0;
			n.key_match = 1'b1;
		end
		return n;
	endfunction

	assign pop_ready = !out_valid_q || out_ready;
	assign take = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_status = status_q;
	assign out_req_len = req_len_q;
	assign out_body_len = body_len_q;

	// accum * 10 + digit, overflow when it leaves the value width
	assign prod = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
		+ {{VALUE_BITS{1'b0}}, pop_item.cls.digit_val};
	assign ovf = |prod[PROD_W-1:VALUE_BITS];
	assign cnt1 = byte_count_q + 32'd1;

	always_comb begin
		byte_count_d = byte_count_q;
		in_body_d = in_body_q;
		window_d = window_q;
		ctl_d = ctl_q;
		accum_d = accum_q;
		held_cr_d = held_cr_q;
		target_d = target_q;
		status_d = ST_PENDING;
		req_len_d = '0;
		body_len_d = '0;
		ctl_a = ctl_q;
		feed_byte = 1'b0;
		cl = '0;
		term_hit = 1'b0;

		if (pop_item.kind) begin
			status_d = ST_CLOSED;
		end else if (in_body_q) begin
			byte_count_d = cnt1;
			if (cnt1 >= target_q) begin
				status_d = ST_COMPLETE;
				req_len_d = target_q;
				body_len_d = accum_q[30:0];
			end
		end else begin
			byte_count_d = cnt1;
			window_d = {window_q[23:0], pop_item.data_byte};

			// a held CR either ends the line with this LF or is fed as a plain char
			held_cr_d = 1'b0;
			if (held_cr_q && pop_item.cls.is_lf) begin
				ctl_a = end_line(ctl_q);
			end else begin
				if (held_cr_q) begin
					ctl_a = feed(ctl_q, CR_CLASS, 1'b0);
				end
				if (pop_item.cls.is_cr) begin
					held_cr_d = 1'b1;
				end else begin
					feed_byte = 1'b1;
				end
			end
			ctl_d = feed_byte ? feed(ctl_a, pop_item.cls, ovf) : ctl_a;
			if (feed_byte && pop_item.cls.is_digit && !ctl_a.value_err && !ovf
				&& (ctl_a.phase == PH_VALUE
				|| (ctl_a.phase == PH_SKIP && !pop_item.cls.is_space))) begin
				accum_d = prod[VALUE_BITS-1:0];
			end

			if (ctl_d.key_found && ctl_d.digit_seen && !ctl_d.value_err) begin
				cl = accum_d;
			end
			term_hit = (cnt1 >= 32'd4) && (window_d == TERMINATOR);

			if (term_hit) begin
				if (cl > {{(VALUE_BITS-31){1'b0}}, body_limit}) begin
					status_d = ST_BODY_TOO_LARGE;
					body_len_d = (|cl[VALUE_BITS-1:31]) ? 31'h7FFF_FFFF : cl[30:0];
				end else begin
					target_d = cnt1 + cl[31:0];
					accum_d = cl;
					if (cl == '0) begin
						status_d = ST_COMPLETE;
						req_len_d = cnt1;
					end else begin
						in_body_d = 1'b1;
					end
				end
			end else if (cnt1 > {16'b0, header_limit}) begin
				status_d = ST_HEADER_TOO_LARGE;
			end
		end

		// any final status starts a fresh request
		if (status_d != ST_PENDING) begin
			byte_count_d = '0;
			in_body_d = 1'b0;
			window_d = '0;
			ctl_d = CTL_RST;
			accum_d = '0;
			held_cr_d = 1'b0;
			target_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			in_body_q <= 1'b0;
			window_q <= '0;
			ctl_q <= CTL_RST;
			accum_q <= '0;
			held_cr_q <= 1'b0;
			target_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				byte_count_q <= byte_count_d;
				in_body_q <= in_body_d;
				window_q <= window_d;
				ctl_q <= ctl_d;
				accum_q <= accum_d;
				held_cr_q <= held_cr_d;
				target_q <= target_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_d;
			req_len_q <= req_len_d;
			body_len_q <= body_len_d;
		end
	end

endmodule

@@ hw/rtl/http_request_framer.sv @@
// path: an accepted item passes the classify stage, a queue slot and the result register
// on its way to the output, and is held back while the output is stalled
// throughput: one item per cycle while the output is not stalled, set by the parse step in the back end
// reset: arst_n clears all request state, the queue and the output valid at once;
// the limit registers return to 8192 and 1048576, no clearing pass is needed
module http_request_framer
	import hrf_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] kind
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] request_length, [62:32] body_length
	output logic [2:0]  m_axis_tuser,   // [2:0] status
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// limit registers, to be written only while the block is idle; the block itself does not enforce this
	logic [15:0] header_limit_q;
	logic [30:0] body_limit_q;
	logic        reg_write;

	// front to queue, queue to back
	logic        push_valid;
	logic        push_ready;
	item_t       push_item;
	logic        pop_valid;
	logic        pop_ready;
	item_t       pop_item;

	status_t     res_status;
	logic [31:0] res_req_len;
	logic [30:0] res_body_len;

	assign pready = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	// register index sits in address bit 2, one word per register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_limit_q <= HEADER_LIMIT_RST;
			body_limit_q <= BODY_LIMIT_RST;
		end else if (reg_write) begin
			case (paddr[2])
				REG_HEADER_LIMIT: header_limit_q <= pwdata[15:0];
				REG_BODY_LIMIT: body_limit_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_HEADER_LIMIT: prdata = {16'b0, header_limit_q};
			REG_BODY_LIMIT: prdata = {1'b0, body_limit_q};
			default: prdata = '0;
		endcase
	end

	// front: accept and classify each byte
	hrf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (s_axis_tuser),
		.in_byte    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// short queue so front and back stall independently
	hrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// back: header parse, length tracking and the result register
	hrf_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.header_limit (header_limit_q),
		.body_limit   (body_limit_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_status   (res_status),
		.out_req_len  (res_req_len),
		.out_body_len (res_body_len)
	);

	assign m_axis_tuser = res_status;
	assign m_axis_tdata = {1'b0, res_body_len, res_req_len};

endmodule

@@ hw/rtl/hrf_checker.sv @@
`include "http_request_framer_macros.svh"

module hrf_checker
	import hrf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	`HRF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
	`HRF_ASSERT_ALWAYS(a_idle_after_reset, $rose(arst_n) |-> !m_axis_tvalid, "result valid straight out of reset")
	`HRF_ASSERT(a_len_only_complete, m_axis_tvalid && m_axis_tuser != ST_COMPLETE |-> m_axis_tdata[31:0] == 32'd0, "request length without completion")
	`HRF_ASSERT(a_body_len_status, m_axis_tvalid && m_axis_tuser != ST_COMPLETE && m_axis_tuser != ST_BODY_TOO_LARGE |-> m_axis_tdata[62:32] == 31'd0, "body length on wrong status")
	`HRF_ASSERT(a_req_covers_body, m_axis_tvalid && m_axis_tuser == ST_COMPLETE |-> m_axis_tdata[31:0] > {1'b0, m_axis_tdata[62:32]}, "request shorter than its body")

endmodule

bind http_request_framer hrf_checker u_hrf_checker (.*);
